[design/wts_pkg.sv]
package wts_pkg;

  // angle and vector widths
  localparam int ANG_W = 24;             // internal angle, 1/16384 degree, signed
  localparam int VEC_W = 34;             // rotation vector component, signed
  localparam int WV_W  = 36;             // vectoring component, signed
  localparam int TAB_LEN = 24;

  localparam logic signed [ANG_W-1:0] ANG_FULL    = 24'sd5898240;
  localparam logic signed [ANG_W-1:0] ANG_HALF    = 24'sd2949120;
  localparam logic signed [ANG_W-1:0] ANG_QUARTER = 24'sd1474560;
  localparam logic [14:0] IN_FULL = 15'd23040;
  localparam logic [15:0] GAIN_INV = 16'd39797;

  // atan(2^-i) in 1/16384 degree
  function automatic logic signed [ANG_W-1:0] atan_tab(input logic [4:0] i);
    case (i)
      5'd0:  atan_tab = 24'sd737280;
      5'd1:  atan_tab = 24'sd435242;
      5'd2:  atan_tab = 24'sd229970;
      5'd3:  atan_tab = 24'sd116736;
      5'd4:  atan_tab = 24'sd58595;
      5'd5:  atan_tab = 24'sd29326;
      5'd6:  atan_tab = 24'sd14667;
      5'd7:  atan_tab = 24'sd7334;
      5'd8:  atan_tab = 24'sd3667;
      5'd9:  atan_tab = 24'sd1833;
      5'd10: atan_tab = 24'sd917;
      5'd11: atan_tab = 24'sd458;
      5'd12: atan_tab = 24'sd229;
      5'd13: atan_tab = 24'sd115;
      5'd14: atan_tab = 24'sd57;
      5'd15: atan_tab = 24'sd29;
      5'd16: atan_tab = 24'sd14;
      5'd17: atan_tab = 24'sd7;
      5'd18: atan_tab = 24'sd4;
      5'd19: atan_tab = 24'sd2;
      5'd20: atan_tab = 24'sd1;
      default: atan_tab = 24'sd0;
    endcase
  endfunction

  // bring a 15 bit angle into 0..23039
  function automatic logic [14:0] reduce_angle(input logic [14:0] a);
    reduce_angle = (a >= IN_FULL) ? a - IN_FULL : a;
  endfunction

endpackage

[design/wind_triangle_solver.sv]
// Wind triangle solver: one measurement set may be transferred in every cycle while the output
// is not stalled. The pipeline is two unrolled CORDIC pipelines in series (rotation for both
// speed vectors in parallel, then vectoring for the wind) plus entry, difference, wrap, scaling
// and rounding stages. A stall on the output freezes the whole pipeline; there is no state
// between items and reset only clears valid.
module wind_triangle_solver #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [13:0] ground_speed,
  input  logic [14:0] ground_track,
  input  logic [13:0] true_airspeed,
  input  logic [14:0] heading,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] wind_speed,
  output logic [14:0] wind_direction,
  output logic        calm,
  output logic [14:0] heading_out
);
  import wts_pkg::*;

  localparam int N   = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
  localparam int LAT = 2 * N + 5;

  logic en;
  logic [LAT-1:0] vld;
  logic [14:0] hd [LAT-1];

  // pipeline advances when the last stage is empty or drained
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // heading travels alongside
  always_ff @(posedge clk) begin
    if (en) begin
      hd[0] <= reduce_angle(heading);
      for (int k = 1; k < LAT - 1; k++) hd[k] <= hd[k-1];
    end
  end

  // speed vectors (N+1 stages)
  logic signed [VEC_W-1:0] ge, gn, ae, an;
  wts_rotate #(.STEPS(N)) u_ground (
    .clk(clk), .en(en), .mag(ground_speed), .ang(ground_track), .east(ge), .north(gn));
  wts_rotate #(.STEPS(N)) u_air (
    .clk(clk), .en(en), .mag(true_airspeed), .ang(heading), .east(ae), .north(an));

  // wind-from vector and half-plane fold
  logic signed [WV_W-1:0] dx, dy;
  logic signed [WV_W-1:0] xv [N+1];
  logic signed [WV_W-1:0] yv [N+1];
  logic signed [ANG_W:0]  zv [N+1];

  assign dx = WV_W'(an) - WV_W'(gn);
  assign dy = WV_W'(ae) - WV_W'(ge);

  always_ff @(posedge clk) begin
    if (en) begin
      if (dx < 0) begin
        xv[0] <= -dx;
        yv[0] <= -dy;
        zv[0] <= (ANG_W+1)'(ANG_HALF);
      end else begin
        xv[0] <= dx;
        yv[0] <= dy;
        zv[0] <= '0;
      end
    end
  end

  // vectoring micro-rotations
  for (genvar i = 0; i < N; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (en) begin
        if (yv[i] >= 0) begin
          xv[i+1] <= xv[i] + (yv[i] >>> i);
          yv[i+1] <= yv[i] - (xv[i] >>> i);
          zv[i+1] <= zv[i] + (ANG_W+1)'(atan_tab(5'(i)));
        end else begin
          xv[i+1] <= xv[i] - (yv[i] >>> i);
          yv[i+1] <= yv[i] + (xv[i] >>> i);
          zv[i+1] <= zv[i] - (ANG_W+1)'(atan_tab(5'(i)));
        end
      end
    end
  end

  // angle wrap and clamp of negative magnitude
  logic signed [ANG_W:0] zw;
  logic [ANG_W-1:0] zr;
  logic [WV_W-1:0]  xp;
  logic [WV_W+15:0] prod;
  always_comb begin
    zw = zv[N];
    if (zw < 0) zw = zw + (ANG_W+1)'(ANG_FULL);
    if (zw >= (ANG_W+1)'(ANG_FULL)) zw = zw - (ANG_W+1)'(ANG_FULL);
    if (zw < 0) zw = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xp <= xv[N][WV_W-1] ? '0 : xv[N];
      zr <= zw[ANG_W-1:0];
    end
  end

  // scaling stage
  logic [ANG_W-1:0] zr2;
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= xp * GAIN_INV;
      zr2  <= zr;
    end
  end

  // rounding, saturation, calm and output register
  logic [WV_W+15:0] sp_full;
  logic [15:0]      dir_r;
  logic [14:0]      spd_c, dir_c;
  always_comb begin
    sp_full = (prod + (WV_W+16)'(64'd1 << 31)) >> 32;
    spd_c = (sp_full > (WV_W+16)'(32767)) ? 15'd32767 : sp_full[14:0];
    dir_r = 16'((25'(zr2) + 25'd128) >> 8);
    if (dir_r >= 16'(IN_FULL)) dir_r = dir_r - 16'(IN_FULL);
    dir_c = (spd_c == '0) ? '0 : dir_r[14:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wind_speed     <= spd_c;
      wind_direction <= dir_c;
      calm           <= (spd_c == '0);
      heading_out    <= hd[LAT-2];
    end
  end

  assign out_valid = vld[LAT-1];

  // checks
  a_calm_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid && calm |-> wind_direction == '0) else $error("calm with direction");
  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> wind_direction < IN_FULL) else $error("direction out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(wind_speed)) else $error("output lost");
endmodule

[design/wts_rotate.sv]
// pipelined rotation cordic: speed and compass angle to east/north vector
module wts_rotate #(
  parameter int STEPS = 16
) (
  input  logic clk,
  input  logic en,
  input  logic [13:0] mag,
  input  logic [14:0] ang,
  output logic signed [wts_pkg::VEC_W-1:0] east,
  output logic signed [wts_pkg::VEC_W-1:0] north
);
  import wts_pkg::*;

  localparam int N = (STEPS > TAB_LEN) ? TAB_LEN : STEPS;

  logic signed [VEC_W-1:0] xs [N+1];
  logic signed [VEC_W-1:0] ys [N+1];
  logic signed [ANG_W-1:0] zs [N+1];
  logic                    ng [N+1];

  logic signed [ANG_W-1:0] z0;
  logic signed [ANG_W-1:0] z1;
  logic                    neg0;

  // quadrant fold into +/- 90 degrees
  always_comb begin
    z0 = ANG_W'($signed({1'b0, reduce_angle(ang), 8'd0}));
    if (z0 > ANG_HALF) z0 = z0 - ANG_FULL;
    neg0 = 1'b0;
    z1 = z0;
    if (z0 > ANG_QUARTER) begin
      z1 = z0 - ANG_HALF;
      neg0 = 1'b1;
    end else if (z0 < -ANG_QUARTER) begin
      z1 = z0 + ANG_HALF;
      neg0 = 1'b1;
    end
  end

  // entry stage: scale by inverse gain
  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= VEC_W'($signed({1'b0, 30'(mag) * 30'(GAIN_INV)}));
      ys[0] <= '0;
      zs[0] <= z1;
      ng[0] <= neg0;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_tab(5'(i));
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_tab(5'(i));
        end
        ng[i+1] <= ng[i];
      end
    end
  end

  assign east  = ng[N] ? -ys[N] : ys[N];
  assign north = ng[N] ? -xs[N] : xs[N];
endmodule

[dv/wind_triangle_solver_tb.sv]
module wind_triangle_solver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = 16;
  localparam int LATENCY = 2 * STEPS + 5;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1800;

  localparam longint FULL_TURN = 5898240;
  localparam longint HALF_TURN = 2949120;
  localparam longint QUARTER_TURN = 1474560;
  localparam longint GAIN_COMP = 39797;
  localparam int DEG_360 = 23040;

  typedef struct packed {
    logic [13:0] gs;
    logic [14:0] trk;
    logic [13:0] tas;
    logic [14:0] hdg;
  } meas_t;

  typedef struct packed {
    logic [14:0] spd;
    logic [14:0] dir;
    logic        calm;
    logic [14:0] hdg;
  } wind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [13:0] ground_speed = '0;
  logic [14:0] ground_track = '0;
  logic [13:0] true_airspeed = '0;
  logic [14:0] heading = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [14:0] wind_speed;
  logic [14:0] wind_direction;
  logic calm;
  logic [14:0] heading_out;

  meas_t pending_meas[$];
  wind_t expected_wind[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit hold_sender = 1'b0;
  bit stim_done = 1'b0;

  wind_triangle_solver #(.CORDIC_STEPS(STEPS)) dut (.*);

  always #1 clk = ~clk;

  // atan(2^-i) in 1/16384 degree
  function automatic longint atan_step(int i);
    longint t[24] = '{737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
                      3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0, 0};
    return t[i];
  endfunction

  function automatic logic [14:0] wrap_angle(logic [14:0] a);
    return (a >= 15'(DEG_360)) ? a - 15'(DEG_360) : a;
  endfunction

  // rotation cordic: speed and compass angle to east/north
  function automatic void compass_vector(logic [13:0] v, logic [14:0] a,
                                         output longint east, output longint north);
    longint z, x, y, nx;
    bit flip;
    z = longint'(wrap_angle(a)) <<< 8;
    flip = 0;
    if (z > HALF_TURN) z -= FULL_TURN;
    if (z > QUARTER_TURN) begin
      z -= HALF_TURN; flip = 1;
    end else if (z < -QUARTER_TURN) begin
      z += HALF_TURN; flip = 1;
    end
    x = longint'(v) * GAIN_COMP;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= atan_step(i);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += atan_step(i);
      end
      x = nx;
    end
    east = flip ? -y : y;
    north = flip ? -x : x;
  endfunction

  function automatic wind_t solve_wind(meas_t m);
    longint ge, gn, ae, an, x, y, z, nx, spd, dir;
    wind_t w;
    compass_vector(m.gs, m.trk, ge, gn);
    compass_vector(m.tas, m.hdg, ae, an);
    x = an - gn;
    y = ae - ge;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = HALF_TURN;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z += atan_step(i);
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= atan_step(i);
      end
      x = nx;
    end
    if (z < 0) z += FULL_TURN;
    if (z >= FULL_TURN) z -= FULL_TURN;
    if (z < 0) z = 0;
    if (x < 0) x = 0;
    spd = (x * GAIN_COMP + (longint'(1) <<< 31)) >>> 32;
    if (spd > 32767) spd = 32767;
    dir = (z + 128) >>> 8;
    if (dir >= DEG_360) dir -= DEG_360;
    w.calm = (spd == 0);
    if (w.calm) dir = 0;
    w.spd = spd[14:0];
    w.dir = dir[14:0];
    w.hdg = wrap_angle(m.hdg);
    return w;
  endfunction

  function automatic meas_t make_meas(int gs, int trk, int tas, int hdg);
    meas_t m;
    m.gs = 14'(gs); m.trk = 15'(trk); m.tas = 14'(tas); m.hdg = 15'(hdg);
    return m;
  endfunction

  // driver: one transfer per queued item with random gaps
  always @(posedge clk) begin
    int gap;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_wind.push_back(solve_wind(pending_meas.pop_front()));
        gap = $urandom_range(0, 7);
        if (gap == 0 && pending_meas.size() > 0 && !hold_sender) begin
          // back to back transfer
          ground_speed <= pending_meas[0].gs;
          ground_track <= pending_meas[0].trk;
          true_airspeed <= pending_meas[0].tas;
          heading <= pending_meas[0].hdg;
        end else begin
          in_valid <= 1'b0;
          send_gap <= (gap > 0) ? gap - 1 : 0;
        end
      end else if (!in_valid) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_meas.size() > 0 && !hold_sender) begin
          in_valid <= 1'b1;
          ground_speed <= pending_meas[0].gs;
          ground_track <= pending_meas[0].trk;
          true_airspeed <= pending_meas[0].tas;
          heading <= pending_meas[0].hdg;
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    wind_t got, want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{wind_speed, wind_direction, calm, heading_out};
        if (expected_wind.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_wind.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
        recv_gap = $urandom_range(0, 7);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (!rst && (pending_meas.size() > 0 || expected_wind.size() > 0 || in_valid)) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int idx;
    int dt;
    // extremes, quadrants, calm, angle wrap
    pending_meas.push_back(make_meas(0, 0, 0, 0));
    pending_meas.push_back(make_meas(16383, 0, 16383, 0));
    pending_meas.push_back(make_meas(16383, 0, 16383, 11520));
    pending_meas.push_back(make_meas(16383, 32767, 0, 32767));
    pending_meas.push_back(make_meas(0, 23039, 16383, 23040));
    pending_meas.push_back(make_meas(1000, 23040, 1000, 0));
    pending_meas.push_back(make_meas(1000, 5760, 1000, 5760));
    pending_meas.push_back(make_meas(1600, 5760, 1600, 17280));
    pending_meas.push_back(make_meas(1600, 11520, 1600, 0));
    pending_meas.push_back(make_meas(1600, 0, 0, 0));
    pending_meas.push_back(make_meas(1600, 11520, 0, 0));
    pending_meas.push_back(make_meas(1600, 5760, 0, 0));
    pending_meas.push_back(make_meas(1600, 17280, 0, 0));
    pending_meas.push_back(make_meas(0, 0, 1600, 11519));
    pending_meas.push_back(make_meas(1, 0, 0, 0));
    pending_meas.push_back(make_meas(1, 100, 1, 23000));
    pending_meas.push_back(make_meas(2000, 2880, 1900, 2900));
    pending_meas.push_back(make_meas(8191, 30000, 8192, 25000));
    pending_meas.push_back(make_meas(16383, 17280, 16383, 5760));
    pending_meas.push_back(make_meas(12000, 8640, 11000, 14400));
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(0, 5))
        0: pending_meas.push_back(make_meas($urandom_range(0, 16383), $urandom_range(0, 32767),
                                            $urandom_range(0, 16383), $urandom_range(0, 32767)));
        1: begin
          // near-calm: ground close to air
          idx = $urandom_range(0, 16383);
          dt = $urandom_range(0, 2);
          pending_meas.push_back(make_meas(idx, $urandom_range(0, 23039),
                                           (idx + dt > 16383) ? idx : idx + dt, 0));
          pending_meas[$].hdg = pending_meas[$].trk;
        end
        default: pending_meas.push_back(make_meas($urandom_range(0, 16383),
                                                  $urandom_range(0, 23039),
                                                  $urandom_range(0, 16383),
                                                  $urandom_range(0, 23039)));
      endcase
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // drain once mid-run
    wait (pending_meas.size() < RANDOM_ITEMS / 2);
    hold_sender = 1'b1;
    wait (!in_valid && expected_wind.size() == 0);
    hold_sender = 1'b0;
    wait (pending_meas.size() == 0 && !in_valid && expected_wind.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_wind.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

[sim.f]
design/wts_pkg.sv
design/wts_rotate.sv
design/wind_triangle_solver.sv
dv/wind_triangle_solver_tb.sv
